/* rtl/ptq_pkg.sv */
// ptq_pkg: shared types and constants for the periodic timer task queue
// used by ptq_scan and periodic_timer_task_queue_top
package ptq_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int MAX_FIRES = 32;
  localparam int FIRE_W    = $clog2(MAX_FIRES + 1);

  typedef enum logic [3:0] {
    ACT_ADD       = 4'd0,
    ACT_ADVANCE   = 4'd1,
    ACT_REM_ID    = 4'd2,
    ACT_REM_GROUP = 4'd3,
    ACT_PAUSE_ID  = 4'd4,
    ACT_RESUME_ID = 4'd5,
    ACT_PAUSE_GRP = 4'd6,
    ACT_RESUME_GRP= 4'd7,
    ACT_NEW_GROUP = 4'd8
  } action_t;

  typedef enum logic [2:0] {
    KIND_FIRED     = 3'd0,
    KIND_ADDED     = 3'd1,
    KIND_ADV_DONE  = 3'd2,
    KIND_GROUP     = 3'd3,
    KIND_OK        = 3'd4,
    KIND_NOT_FOUND = 3'd5,
    KIND_FULL      = 3'd6
  } kind_t;

  // one table entry as seen by the scan unit
  typedef struct packed {
    logic        valid;
    logic        paused;
    logic [31:0] due;
    logic [31:0] stamp;
  } scan_entry_t;

  // scan unit control from the sequencer
  typedef struct packed {
    logic        start;
    logic [31:0] target;
  } scan_ctl_t;

  // scan unit status back to the sequencer
  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] best;
  } scan_stat_t;

endpackage

/* rtl/ptq_scan.sv */
// ptq_scan: iterative earliest-due search, one table entry per cycle
// depends on ptq_pkg
module ptq_scan (
  input  logic                 clk,
  input  logic                 rst,
  input  ptq_pkg::scan_ctl_t   ctl,
  input  ptq_pkg::scan_entry_t ent,
  output logic [ptq_pkg::IDX_W-1:0] idx,
  output ptq_pkg::scan_stat_t  stat
);

  logic                      busy;
  logic                      found;
  logic                      done_q;
  logic [ptq_pkg::IDX_W-1:0] best;
  logic [31:0]               best_due;
  logic [31:0]               best_stamp;
  logic                      take;
  logic [ptq_pkg::IDX_W-1:0] idx_cnt;

  assign idx = busy ? idx_cnt : '0;

  // shared compare unit: candidate beats current best
  always_comb begin
    take = ent.valid && !ent.paused && (ent.due <= ctl.target) &&
           (!found || ent.due < best_due ||
            (ent.due == best_due && ent.stamp < best_stamp));
  end

  // scan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      found   <= 1'b0;
      idx_cnt <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctl.start && !busy) begin
        busy    <= 1'b1;
        found   <= 1'b0;
        idx_cnt <= '0;
      end else if (busy) begin
        if (take) begin
          found      <= 1'b1;
          best       <= idx_cnt;
          best_due   <= ent.due;
          best_stamp <= ent.stamp;
        end
        if (idx_cnt == ptq_pkg::IDX_W'(ptq_pkg::ENTRIES - 1)) begin
          busy   <= 1'b0;
          done_q <= 1'b1;
        end
        idx_cnt <= idx_cnt + 1'b1;
      end
    end
  end

  // result as seen in the cycle after the last entry
  always_comb begin
    stat.done  = done_q;
    stat.found = found;
    stat.best  = best;
  end

endmodule

/* rtl/periodic_timer_task_queue_top.sv */
// periodic_timer_task_queue_top: timed task table with add, advance, pause,
// resume and remove; depends on ptq_pkg and ptq_scan
//
// usage: one input channel (in_valid/in_stall) carries an action and its
// arguments; one output channel (out_valid/out_stall) returns result items,
// the final one of each action with last set. An advance returns one fired
// item per firing, earliest first (at most MAX_FIRES), then an advance-done
// item. in_stall is high from the transfer of an action until its last
// result has been taken.
// operation: every action first walks the 16-entry table one entry a cycle.
// An add then fills the free slot and returns its result; the id/group
// actions and new group return their result after the walk. An advance walks
// the table once to push back paused tasks, then runs one full scan per
// firing through the shared compare unit, followed by the fire and hold
// states, until no due task is left or the fire limit is reached.
// reset: synchronous, clears valid and paused bits, time and the id, group
// and stamp counters; the block is ready the cycle after reset. When the
// receiver stalls, the result register holds and the sequencer waits.
module periodic_timer_task_queue_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  action,
  input  logic [31:0] task_ident,
  input  logic [31:0] group_ident,
  input  logic [31:0] start_offset,
  input  logic [31:0] period_ticks,
  input  logic [31:0] duration_ticks,
  input  logic [31:0] advance_ticks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [31:0] out_task,
  output logic [31:0] out_group,
  output logic [31:0] fire_time,
  output logic        last
);

  localparam int N = ptq_pkg::ENTRIES;
  localparam int W = ptq_pkg::IDX_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_WALK  = 8'b00000010,
    S_SCAN  = 8'b00000100,
    S_WAIT  = 8'b00001000,
    S_FIRE  = 8'b00010000,
    S_EMIT  = 8'b00100000,
    S_HOLD  = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t state;

  // table
  logic [N-1:0] valid_q, paused_q;
  logic [31:0]  id_m [N], grp_m [N], due_m [N], per_m [N], end_m [N], stamp_m [N];

  logic [31:0] current_time, id_counter, group_counter, stamp_counter;
  logic [3:0]  act;
  logic [31:0] a_tid, a_gid, a_start, a_per, a_dur, a_adv, target;
  logic [W-1:0] walk;
  logic        hit;
  logic [ptq_pkg::FIRE_W-1:0] fires;
  logic [W-1:0] fb;

  // scan unit
  ptq_pkg::scan_ctl_t   sctl;
  ptq_pkg::scan_entry_t sent;
  ptq_pkg::scan_stat_t  sstat;
  logic [W-1:0]         sidx;

  assign sctl.start  = (state == S_SCAN);
  assign sctl.target = target;
  assign sent.valid  = valid_q[sidx];
  assign sent.paused = paused_q[sidx];
  assign sent.due    = due_m[sidx];
  assign sent.stamp  = stamp_m[sidx];

  ptq_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .ctl  (sctl),
    .ent  (sent),
    .idx  (sidx),
    .stat (sstat)
  );

  assign in_stall = (state != S_IDLE);

  logic by_group, match, id_or_group;
  logic [31:0] nd;
  assign by_group = (act == ptq_pkg::ACT_REM_GROUP) || (act == ptq_pkg::ACT_PAUSE_GRP) ||
                    (act == ptq_pkg::ACT_RESUME_GRP);
  assign id_or_group = (act >= ptq_pkg::ACT_REM_ID) && (act <= ptq_pkg::ACT_RESUME_GRP);
  assign match = valid_q[walk] &&
                 (by_group ? (grp_m[walk] == a_gid) : (id_m[walk] == a_tid));
  assign nd = due_m[fb] + per_m[fb];

  // result helper
  logic        emit_go;
  logic [2:0]  e_kind;
  logic [31:0] e_task, e_group, e_time;
  logic        e_last;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      valid_q       <= '0;
      paused_q      <= '0;
      current_time  <= '0;
      id_counter    <= '0;
      group_counter <= '0;
      stamp_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            act     <= action;
            a_tid   <= task_ident;
            a_gid   <= group_ident;
            a_start <= start_offset;
            a_per   <= period_ticks;
            a_dur   <= duration_ticks;
            a_adv   <= advance_ticks;
            target  <= current_time + advance_ticks;
            walk    <= '0;
            hit     <= 1'b0;
            fires   <= '0;
            state   <= S_WALK;
          end
        end
        // one entry per cycle over the table
        S_WALK: begin
          priority if (act == ptq_pkg::ACT_ADD) begin
            if (!valid_q[walk] && !hit) begin
              hit           <= 1'b1;
              fb            <= walk;
            end
          end else if (act == ptq_pkg::ACT_ADVANCE) begin
            if (valid_q[walk] && paused_q[walk]) due_m[walk] <= due_m[walk] + a_adv;
          end else if (id_or_group) begin
            if (match) begin
              hit <= 1'b1;
              if (act == ptq_pkg::ACT_REM_ID || act == ptq_pkg::ACT_REM_GROUP) begin
                valid_q[walk]  <= 1'b0;
                paused_q[walk] <= 1'b0;
              end else if (act == ptq_pkg::ACT_PAUSE_ID ||
                           act == ptq_pkg::ACT_PAUSE_GRP) begin
                paused_q[walk] <= 1'b1;
              end else if (paused_q[walk]) begin
                paused_q[walk] <= 1'b0;
                stamp_m[walk]  <= stamp_counter;
                stamp_counter  <= stamp_counter + 1'b1;
              end
            end
          end else begin
          end
          walk <= walk + 1'b1;
          if (walk == W'(N - 1)) begin
            state <= (act == ptq_pkg::ACT_ADVANCE) ? S_SCAN :
                     (act == ptq_pkg::ACT_ADD) ? S_FIRE : S_EMIT;
          end
        end
        S_SCAN: begin
          if (fires == ptq_pkg::FIRE_W'(ptq_pkg::MAX_FIRES)) state <= S_EMIT;
          else state <= S_WAIT;
        end
        S_WAIT: begin
          if (sstat.done) begin
            if (sstat.found) begin
              fb    <= sstat.best;
              state <= S_FIRE;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        // add: fill the free slot if one was found; advance: emit the winner and requeue or retire it
        S_FIRE: begin
          if (!out_valid || !out_stall) begin
            if (act == ptq_pkg::ACT_ADD) begin
              if (hit) begin
                valid_q[fb]  <= 1'b1;
                paused_q[fb] <= 1'b0;
                id_m[fb]     <= id_counter + 1'b1;
                grp_m[fb]    <= a_gid;
                due_m[fb]    <= current_time + a_start;
                per_m[fb]    <= a_per;
                end_m[fb]    <= (a_dur == '0) ? '0 : current_time + a_start + a_dur;
                stamp_m[fb]  <= stamp_counter;
                stamp_counter<= stamp_counter + 1'b1;
                id_counter   <= id_counter + 1'b1;
              end
              state <= S_EMIT;
            end else begin
              current_time <= due_m[fb];
              if (per_m[fb] != '0 && (end_m[fb] == '0 || end_m[fb] >= nd)) begin
                due_m[fb]     <= nd;
                stamp_m[fb]   <= stamp_counter;
                stamp_counter <= stamp_counter + 1'b1;
              end else begin
                valid_q[fb] <= 1'b0;
              end
              fires <= fires + 1'b1;
              state <= S_HOLD;
            end
          end
        end
        S_HOLD: state <= S_SCAN;
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            if (act == ptq_pkg::ACT_ADVANCE) current_time <= target;
            if (act == ptq_pkg::ACT_NEW_GROUP) group_counter <= group_counter + 1'b1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      // result register: load a new item or clear after its transfer
      if (emit_go) begin
        out_valid <= 1'b1;
        kind      <= e_kind;
        out_task  <= e_task;
        out_group <= e_group;
        fire_time <= e_time;
        last      <= e_last;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result item selection
  always_comb begin
    emit_go = 1'b0;
    e_kind  = ptq_pkg::KIND_NOT_FOUND;
    e_task  = '0;
    e_group = '0;
    e_time  = current_time;
    e_last  = 1'b1;
    if ((!out_valid || !out_stall)) begin
      if (state == S_FIRE && act == ptq_pkg::ACT_ADVANCE) begin
        emit_go = 1'b1;
        e_kind  = ptq_pkg::KIND_FIRED;
        e_task  = id_m[fb];
        e_group = grp_m[fb];
        e_time  = due_m[fb];
        e_last  = 1'b0;
      end else if (state == S_EMIT) begin
        emit_go = 1'b1;
        priority if (act == ptq_pkg::ACT_ADD) begin
          if (hit) begin
            e_kind  = ptq_pkg::KIND_ADDED;
            e_task  = id_counter;
            e_group = a_gid;
          end else begin
            e_kind = ptq_pkg::KIND_FULL;
          end
        end else if (act == ptq_pkg::ACT_ADVANCE) begin
          e_kind = ptq_pkg::KIND_ADV_DONE;
          e_time = target;
        end else if (act == ptq_pkg::ACT_NEW_GROUP) begin
          e_kind  = ptq_pkg::KIND_GROUP;
          e_group = group_counter + 1'b1;
        end else if (id_or_group) begin
          e_kind = hit ? ptq_pkg::KIND_OK : ptq_pkg::KIND_NOT_FOUND;
        end else begin
          e_kind = ptq_pkg::KIND_NOT_FOUND;
        end
      end
    end
  end

endmodule
